[rtl/gom_pkg.sv]
// gom_pkg: shared types and codes for the grid occupancy map.
// No dependencies; imported by gom_map_mem, gom_ctrl and grid_occupancy_map.
package gom_pkg;

	localparam int REQ_W = 3;
	localparam int POS_W = 4;
	localparam int CFG_W = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [REQ_W-1:0] REQ_TEST_AREA  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SET_AREA   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR_AREA = 3'd2;
	localparam logic [REQ_W-1:0] REQ_TEST_CELL  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SET_CELL   = 3'd4;
	localparam logic [REQ_W-1:0] REQ_CLEAR_CELL = 3'd5;
	localparam logic [REQ_W-1:0] REQ_CLEAR_ALL  = 3'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} gom_state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wipe;
	} gom_mem_ctl_t;

endpackage

[rtl/gom_map_mem.sv]
// gom_map_mem: row-word occupancy memory, one read and one write port, registered read.
// Per-row valid flags give an all-zero map after reset or wipe. Uses gom_pkg.
module gom_map_mem #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16,
	parameter int ROW_AW = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gom_pkg::gom_mem_ctl_t mem_ctl,
	input  logic [ROW_AW-1:0]    rd_addr,
	input  logic [ROW_AW-1:0]    wr_addr,
	input  logic [MAX_COLS-1:0]  wr_data,
	output logic [MAX_COLS-1:0]  rd_data
);
	import gom_pkg::*;

	logic [MAX_COLS-1:0] mem_q [MAX_ROWS];
	logic [MAX_ROWS-1:0] row_vld_q;
	logic [MAX_COLS-1:0] rd_word_s1;
	logic                rd_vld_s1;

	always_ff @(posedge clk) begin
		if (mem_ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (mem_ctl.rd_en) begin
			rd_word_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (mem_ctl.wipe) begin
				row_vld_q <= '0;
			end else if (mem_ctl.wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (mem_ctl.rd_en) begin
				rd_vld_s1 <= row_vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_s1 ? rd_word_s1 : '0;

endmodule

[rtl/gom_ctrl.sv]
// gom_ctrl: request decode, rectangle check, size registers and row sequencer.
// Scans a row word each cycle; set and clear write the new word back the cycle after. Uses gom_pkg.
module gom_ctrl #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16,
	parameter int ROW_AW = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [gom_pkg::REQ_W-1:0]       req_type,
	input  logic [gom_pkg::POS_W-1:0]       first_row,
	input  logic [gom_pkg::POS_W-1:0]       first_col,
	input  logic [gom_pkg::POS_W-1:0]       last_row,
	input  logic [gom_pkg::POS_W-1:0]       last_col,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gom_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gom_pkg::CFG_W-1:0]       cfg_data,
	output logic                            done,
	output logic                            any_occupied,
	output logic                            status,
	output gom_pkg::gom_mem_ctl_t           mem_ctl,
	output logic [ROW_AW-1:0]               rd_addr,
	output logic [ROW_AW-1:0]               wr_addr,
	output logic [MAX_COLS-1:0]             wr_data,
	input  logic [MAX_COLS-1:0]             rd_data
);
	import gom_pkg::*;

	localparam int CMP_W = 9;
	localparam logic [CFG_W-1:0] ROWS_RST = CFG_W'((MAX_ROWS < 16) ? MAX_ROWS : 16);
	localparam logic [CFG_W-1:0] COLS_RST = CFG_W'((MAX_COLS < 16) ? MAX_COLS : 16);

	gom_state_t state_q, state_d;

	logic [CFG_W-1:0]    rows_q, cols_q;
	logic [REQ_W-1:0]    kind_q;
	logic [POS_W-1:0]    row_q, last_q;
	logic [MAX_COLS-1:0] mask_q, mask_d;
	logic                found_q;
	logic                vld_s1;
	logic [ROW_AW-1:0]   row_s1;
	logic                done_q, any_q, status_q;

	logic accept, cfg_we, rect_ok, scan_go, is_cell_wr, is_test, is_set, hit;

	assign accept = start && !busy;
	assign cfg_we = cfg_valid && cfg_ready;

	assign rect_ok = (first_row <= last_row)
		&& ({1'b0, last_row} < rows_q)
		&& (CMP_W'(last_row) < CMP_W'(MAX_ROWS))
		&& (first_col <= last_col)
		&& ({1'b0, last_col} < cols_q)
		&& (CMP_W'(last_col) < CMP_W'(MAX_COLS));

	always_comb begin
		is_cell_wr = req_type inside {REQ_SET_CELL, REQ_CLEAR_CELL};
		scan_go = rect_ok && (req_type <= REQ_CLEAR_CELL);
		for (int i = 0; i < MAX_COLS; i++) begin
			if (is_cell_wr) begin
				mask_d[i] = (i == int'(first_col));
			end else begin
				mask_d[i] = (i >= int'(first_col)) && (i <= int'(last_col));
			end
		end
	end

	// row word arriving from memory
	always_comb begin
		is_test = kind_q inside {REQ_TEST_AREA, REQ_TEST_CELL};
		is_set = kind_q inside {REQ_SET_AREA, REQ_SET_CELL};
		hit = vld_s1 && is_test && (|(rd_data & mask_q));
		wr_data = is_set ? (rd_data | mask_q) : (rd_data & ~mask_q);
		wr_addr = row_s1;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && scan_go) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (row_q == last_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy = 1'b1;
		cfg_ready = 1'b0;
		mem_ctl.rd_en = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				cfg_ready = 1'b1;
			end
			ST_SCAN: begin
				mem_ctl.rd_en = 1'b1;
			end
			ST_DRAIN: begin
				busy = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
		mem_ctl.wr_en = vld_s1 && !is_test;
		mem_ctl.wipe = cfg_we || (accept && (req_type == REQ_CLEAR_ALL));
		rd_addr = ROW_AW'(row_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rows_q <= ROWS_RST;
			cols_q <= COLS_RST;
			vld_s1 <= 1'b0;
			found_q <= 1'b0;
			done_q <= 1'b0;
			any_q <= 1'b0;
			status_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1 <= (state_q == ST_SCAN);
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROWS: begin
						rows_q <= (CMP_W'(cfg_data) > CMP_W'(MAX_ROWS)) ?
							CFG_W'(MAX_ROWS) : cfg_data;
					end
					CFG_COLS: begin
						cols_q <= (CMP_W'(cfg_data) > CMP_W'(MAX_COLS)) ?
							CFG_W'(MAX_COLS) : cfg_data;
					end
					default: begin
						rows_q <= rows_q;
					end
				endcase
			end
			if (accept) begin
				found_q <= 1'b0;
			end else if (hit) begin
				found_q <= 1'b1;
			end
			done_q <= (accept && !scan_go) || (state_q == ST_DRAIN);
			if (accept && !scan_go) begin
				any_q <= 1'b0;
				status_q <= (req_type <= REQ_CLEAR_CELL);
			end else if (state_q == ST_DRAIN) begin
				any_q <= found_q || hit;
				status_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req_type;
			row_q <= first_row;
			last_q <= is_cell_wr ? first_row : last_row;
			mask_q <= mask_d;
		end else if (state_q == ST_SCAN && row_q != last_q) begin
			row_q <= row_q + POS_W'(1);
		end
		row_s1 <= ROW_AW'(row_q);
	end

	assign done = done_q;
	assign any_occupied = any_q;
	assign status = status_q;

endmodule

[rtl/grid_occupancy_map.sv]
// grid_occupancy_map: top level of the rectangle occupancy bitmap.
// Instantiates gom_ctrl and gom_map_mem; uses gom_pkg.
//
// A request is taken when start is high and busy is low; its result shows on
// any_occupied and status for the single cycle in which done is high, and
// must be captured then, as the block cannot be held off. A rectangle request
// reads one row word per cycle through the registered-read memory and, unless
// it is a test, writes it back the cycle after; cell set and clear scan the row
// first_row alone. Clear all, an invalid rectangle and the unused code answer
// in the next cycle.
// The map is all zero after reset, after clear all and after any size register
// write, with no clearing pass. Size registers are written only while busy is low.
module grid_occupancy_map #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [gom_pkg::REQ_W-1:0]     req_type,
	input  logic [gom_pkg::POS_W-1:0]     first_row,
	input  logic [gom_pkg::POS_W-1:0]     first_col,
	input  logic [gom_pkg::POS_W-1:0]     last_row,
	input  logic [gom_pkg::POS_W-1:0]     last_col,
	output logic                          done,
	output logic                          any_occupied,
	output logic                          status,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gom_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gom_pkg::CFG_W-1:0]     cfg_data
);
	import gom_pkg::*;

	localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	gom_mem_ctl_t        mem_ctl;
	logic [ROW_AW-1:0]   rd_addr, wr_addr;
	logic [MAX_COLS-1:0] wr_data, rd_data;

	gom_ctrl #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS),
		.ROW_AW(ROW_AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.first_row(first_row),
		.first_col(first_col),
		.last_row(last_row),
		.last_col(last_col),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.any_occupied(any_occupied),
		.status(status),
		.mem_ctl(mem_ctl),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_data(rd_data)
	);

	gom_map_mem #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS),
		.ROW_AW(ROW_AW)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.mem_ctl(mem_ctl),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_data(rd_data)
	);

endmodule

[rtl/gom_checker.sv]
// gom_checker: port-level assertions for grid_occupancy_map, with its bind.
// Sees the top level's ports only; no package dependency.
module gom_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic any_occupied,
	input logic status,
	input logic cfg_valid,
	input logic cfg_ready
);

	// an accepted word either answers next cycle or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted request neither busy nor answered");

	// a result always follows an accepted word or a busy cycle
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(busy)))
		else $error("result strobe without a request");

	// a rejected rectangle never reports occupancy
	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> !any_occupied)
		else $error("invalid rectangle reported occupancy");

	// size registers are open exactly when requests are
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == !busy)
		else $error("configuration ready while busy");

endmodule

bind grid_occupancy_map gom_checker u_gom_checker (.*);

[tb/testbench.sv]
// testbench: self-checking bench for grid_occupancy_map, directed table then random requests.
// Depends on gom_pkg and grid_occupancy_map only; keeps its own copy of the bitmap and sizes.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gom_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int GRID_MAX = 16;

	typedef struct packed {
		logic [REQ_W-1:0] kind;
		logic [POS_W-1:0] r0;
		logic [POS_W-1:0] c0;
		logic [POS_W-1:0] r1;
		logic [POS_W-1:0] c1;
		logic pinned;
		logic pin_hit;
		logic pin_bad;
	} grid_req_t;

	typedef struct packed {
		logic occ_hit;
		logic bad_rect;
	} map_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS;
	logic [CFG_W-1:0] cfg_data = '0;
	grid_req_t req_word = '0;
	logic busy, done, any_occupied, status, cfg_ready;

	logic [15:0] occ_rows [GRID_MAX];
	logic [4:0] grid_rows = 5'd16;
	logic [4:0] grid_cols = 5'd16;
	map_reply_t replies_due [$];
	bit failed = 1'b0;
	int gap_pct = 0;
	int stim_rows = 16;
	int stim_cols = 16;
	int unsigned cycle_count = 0;

	grid_req_t script [25] = '{
		'{REQ_TEST_AREA,  4'd0,  4'd0,  4'd15, 4'd15, 1'b1, 1'b0, 1'b0},
		'{REQ_TEST_CELL,  4'd0,  4'd0,  4'd15, 4'd15, 1'b1, 1'b0, 1'b0},
		'{REQ_SET_AREA,   4'd0,  4'd0,  4'd0,  4'd0,  1'b1, 1'b0, 1'b0},
		'{REQ_SET_AREA,   4'd15, 4'd15, 4'd15, 4'd15, 1'b0, 1'b0, 1'b0},
		'{REQ_TEST_AREA,  4'd0,  4'd0,  4'd15, 4'd15, 1'b0, 1'b0, 1'b0},
		'{REQ_TEST_CELL,  4'd8,  4'd8,  4'd15, 4'd15, 1'b0, 1'b0, 1'b0},
		'{REQ_SET_CELL,   4'd5,  4'd7,  4'd15, 4'd15, 1'b0, 1'b0, 1'b0},
		'{REQ_TEST_AREA,  4'd6,  4'd8,  4'd14, 4'd14, 1'b0, 1'b0, 1'b0},
		'{REQ_TEST_CELL,  4'd5,  4'd7,  4'd5,  4'd7,  1'b0, 1'b0, 1'b0},
		'{REQ_CLEAR_CELL, 4'd5,  4'd7,  4'd5,  4'd7,  1'b0, 1'b0, 1'b0},
		'{REQ_TEST_AREA,  4'd5,  4'd7,  4'd5,  4'd7,  1'b0, 1'b0, 1'b0},
		'{REQ_SET_AREA,   4'd2,  4'd3,  4'd9,  4'd12, 1'b0, 1'b0, 1'b0},
		'{REQ_CLEAR_AREA, 4'd4,  4'd5,  4'd6,  4'd10, 1'b0, 1'b0, 1'b0},
		'{REQ_TEST_AREA,  4'd4,  4'd5,  4'd6,  4'd10, 1'b0, 1'b0, 1'b0},
		'{REQ_TEST_AREA,  4'd3,  4'd3,  4'd9,  4'd12, 1'b0, 1'b0, 1'b0},
		'{REQ_SET_AREA,   4'd9,  4'd0,  4'd8,  4'd15, 1'b1, 1'b0, 1'b1},
		'{REQ_TEST_AREA,  4'd0,  4'd9,  4'd0,  4'd8,  1'b1, 1'b0, 1'b1},
		'{REQ_SET_CELL,   4'd3,  4'd3,  4'd2,  4'd3,  1'b1, 1'b0, 1'b1},
		'{REQ_UNUSED,     4'd15, 4'd15, 4'd15, 4'd15, 1'b1, 1'b0, 1'b0},
		'{REQ_CLEAR_ALL,  4'd15, 4'd0,  4'd0,  4'd0,  1'b1, 1'b0, 1'b0},
		'{REQ_TEST_AREA,  4'd0,  4'd0,  4'd15, 4'd15, 1'b1, 1'b0, 1'b0},
		'{REQ_SET_AREA,   4'd0,  4'd0,  4'd15, 4'd15, 1'b0, 1'b0, 1'b0},
		'{REQ_TEST_CELL,  4'd15, 4'd15, 4'd15, 4'd15, 1'b0, 1'b0, 1'b0},
		'{REQ_CLEAR_AREA, 4'd0,  4'd0,  4'd15, 4'd15, 1'b0, 1'b0, 1'b0},
		'{REQ_TEST_AREA,  4'd0,  4'd0,  4'd15, 4'd15, 1'b0, 1'b0, 1'b0}
	};

	// rows, cols, sender idle percentage, word count per phase
	int ph_rows [6] = '{16, 1, 16, 31, 0, 9};
	int ph_cols [6] = '{16, 16, 1, 7, 0, 12};
	int ph_gap [6] = '{0, 76, 0, 26, 0, 76};
	int ph_words [6] = '{150, 80, 80, 100, 20, 100};

	grid_occupancy_map DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_word.kind),
		.first_row(req_word.r0),
		.first_col(req_word.c0),
		.last_row(req_word.r1),
		.last_col(req_word.c1),
		.done(done),
		.any_occupied(any_occupied),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void wipe_grid();
		for (int r = 0; r < GRID_MAX; r++) begin
			occ_rows[r] = '0;
		end
	endfunction

	function automatic void resize_grid(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] val);
		logic [4:0] lim;
		lim = (val > GRID_MAX) ? 5'(GRID_MAX) : val;
		if (idx == CFG_ROWS) begin
			grid_rows = lim;
		end else begin
			grid_cols = lim;
		end
		wipe_grid();
	endfunction

	function automatic map_reply_t apply_request(input grid_req_t rq);
		map_reply_t rep;
		logic [15:0] span;
		rep = '0;
		if (rq.kind == REQ_CLEAR_ALL) begin
			wipe_grid();
		end else if (rq.kind != REQ_UNUSED) begin
			if (!(rq.r0 <= rq.r1 && rq.r1 < grid_rows && rq.c0 <= rq.c1 && rq.c1 < grid_cols)) begin
				rep.bad_rect = 1'b1;
			end else if (rq.kind == REQ_SET_CELL) begin
				occ_rows[rq.r0][rq.c0] = 1'b1;
			end else if (rq.kind == REQ_CLEAR_CELL) begin
				occ_rows[rq.r0][rq.c0] = 1'b0;
			end else begin
				span = (16'hFFFF << rq.c0) & (16'hFFFF >> (15 - rq.c1));
				for (int r = rq.r0; r <= rq.r1; r++) begin
					case (rq.kind)
						REQ_TEST_AREA, REQ_TEST_CELL: begin
							if ((occ_rows[r] & span) != 0)
								rep.occ_hit = 1'b1;
						end
						REQ_SET_AREA: begin
							occ_rows[r] = occ_rows[r] | span;
						end
						default: begin
							occ_rows[r] = occ_rows[r] & ~span;
						end
					endcase
				end
			end
		end
		return rep;
	endfunction

	initial wipe_grid();

	always @(posedge clk) begin : watch
		map_reply_t got, want;
		if (arst_n) begin
			if (done) begin
				got = '{any_occupied, status};
				if (replies_due.size() == 0) begin
					$error("result word with no request pending");
					failed = 1'b1;
				end else begin
					want = replies_due.pop_front();
					if (got.occ_hit !== want.occ_hit) begin
						$error("any_occupied: expected %0d, got %0d", want.occ_hit, got.occ_hit);
						failed = 1'b1;
					end
					if (got.bad_rect !== want.bad_rect) begin
						$error("status: expected %0d, got %0d", want.bad_rect, got.bad_rect);
						failed = 1'b1;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				resize_grid(cfg_index, cfg_data);
			if (start && !busy) begin
				want = apply_request(req_word);
				if (req_word.pinned)
					want = '{req_word.pin_hit, req_word.pin_bad};
				replies_due.push_back(want);
			end
		end
	end

	function automatic grid_req_t random_req();
		grid_req_t rq;
		int t;
		logic [POS_W-1:0] tmp;
		rq = '0;
		rq.kind = REQ_W'($urandom_range(0, 7));
		rq.r0 = POS_W'($urandom());
		rq.c0 = POS_W'($urandom());
		rq.r1 = POS_W'($urandom());
		rq.c1 = POS_W'($urandom());
		t = $urandom_range(0, 99);
		if (t < 88 && stim_rows > 0 && stim_cols > 0) begin
			rq.r0 = POS_W'($urandom_range(0, stim_rows - 1));
			rq.r1 = POS_W'($urandom_range(rq.r0, stim_rows - 1));
			rq.c0 = POS_W'($urandom_range(0, stim_cols - 1));
			rq.c1 = POS_W'($urandom_range(rq.c0, stim_cols - 1));
			if (t < 22) rq.kind = REQ_TEST_AREA;
			else if (t < 36) rq.kind = REQ_SET_AREA;
			else if (t < 46) rq.kind = REQ_CLEAR_AREA;
			else if (t < 58) rq.kind = REQ_TEST_CELL;
			else if (t < 74) rq.kind = REQ_SET_CELL;
			else if (t < 85) rq.kind = REQ_CLEAR_CELL;
			else if (t < 86) rq.kind = REQ_CLEAR_ALL;
			else begin
				// corners swapped
				rq.kind = REQ_W'($urandom_range(0, 5));
				tmp = rq.r0;
				rq.r0 = rq.r1;
				rq.r1 = tmp;
				tmp = rq.c0;
				rq.c0 = rq.c1;
				rq.c1 = tmp;
			end
		end
		return rq;
	endfunction

	task automatic send_req(input grid_req_t rq);
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req_word <= rq;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		do @(posedge clk); while (!cfg_ready);
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (script[i])
			send_req(script[i]);
		for (int p = 0; p < 6; p++) begin
			drain();
			write_size(CFG_ROWS, ph_rows[p]);
			write_size(CFG_COLS, ph_cols[p]);
			cfg_valid <= 1'b0;
			stim_rows = (ph_rows[p] > GRID_MAX) ? GRID_MAX : ph_rows[p];
			stim_cols = (ph_cols[p] > GRID_MAX) ? GRID_MAX : ph_cols[p];
			gap_pct = ph_gap[p];
			repeat (ph_words[p])
				send_req(random_req());
		end
		drain();
		if (!failed && replies_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
